@@ rtl/core/lrig_pkg.sv @@
// Package for the minimal-standard Lehmer integer generator.
// Holds generator constants, field widths and the control state type.
// No dependencies.
`default_nettype none
package lrig_pkg;

  localparam int unsigned StateW = 31;
  localparam int unsigned MultW  = 15;
  localparam int unsigned ProdW  = StateW + MultW;
  localparam int unsigned DataW  = 32;
  localparam int unsigned SpanW  = DataW + 1;
  localparam int unsigned CntW   = 5;

  localparam logic [MultW-1:0]  LcgMult  = 15'd16807;
  localparam logic [StateW-1:0] LcgMod   = 31'h7FFF_FFFF;
  localparam logic [StateW-1:0] SeedRst  = 31'd1;
  localparam logic [CntW-1:0]   DivLast  = 5'(StateW - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FOLD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } ctrl_state_e;

endpackage
`default_nettype wire

@@ rtl/core/lrig_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on lrig_pkg for field widths.
`default_nettype none
interface lrig_req_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [lrig_pkg::DataW-1:0]   range_low;
  logic signed [lrig_pkg::DataW-1:0]   range_high;

  modport source (output valid, kind, range_low, range_high, input ready);
  modport sink   (input valid, kind, range_low, range_high, output ready);
endinterface

interface lrig_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [lrig_pkg::DataW-1:0]   value;
  logic                                range_error;

  modport source (output valid, value, range_error, input ready);
  modport sink   (input valid, value, range_error, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lrig_serial_mod.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on lrig_pkg for widths and the step count.
`default_nettype none
module lrig_serial_mod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lrig_pkg::StateW-1:0] dividend_i,
  input  wire logic [lrig_pkg::SpanW-1:0]  divisor_i,
  output logic                             done_o,
  output logic [lrig_pkg::SpanW-1:0]       rem_o
);

  logic [lrig_pkg::StateW-1:0] dvd_q, dvd_d;
  logic [lrig_pkg::SpanW-1:0]  dsr_q, dsr_d;
  logic [lrig_pkg::SpanW-1:0]  rem_q, rem_d;
  logic [lrig_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [lrig_pkg::SpanW:0]    trial;

  always_comb begin
    trial  = {rem_q, dvd_q[lrig_pkg::StateW-1]};
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      dvd_d = {dvd_q[lrig_pkg::StateW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = lrig_pkg::SpanW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = lrig_pkg::SpanW'(trial);
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lrig_pkg::DivLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ rtl/core/lehmer_random_integer_generator_top.sv @@
// Minimal-standard Lehmer generator, x <- 16807*x mod (2^31-1), with ranged output.
// Raw or inverted-range request: ST_MUL, ST_FOLD, ST_DONE, then the result register;
// a ranged request also waits in ST_DIV on the 31-step bit-serial remainder unit.
// Throughput: one request at a time; a new request is taken while a result waits.
// Reset (async, active low): state loads 1, no result pending. Depends on lrig_pkg,
// lrig_req_if, lrig_rsp_if and lrig_serial_mod.
`default_nettype none
module lehmer_random_integer_generator_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lrig_pkg::StateW-1:0] cfg_wdata_i,
  lrig_req_if.sink                         req_i,
  lrig_rsp_if.source                       rsp_o
);

  lrig_pkg::ctrl_state_e       state_q, state_d;
  logic [lrig_pkg::StateW-1:0] gen_q, gen_d;
  logic [lrig_pkg::ProdW-1:0]  prod_q, prod_d;
  logic                        kind_q, kind_d;
  logic                        err_q, err_d;
  logic [lrig_pkg::DataW-1:0]  lo_q, lo_d;
  logic [lrig_pkg::SpanW-1:0]  span_q, span_d;
  logic [lrig_pkg::DataW-1:0]  res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  logic [lrig_pkg::DataW-1:0]  out_value_q, out_value_d;
  logic                        out_err_q, out_err_d;

  logic                        req_fire;
  logic [lrig_pkg::DataW-1:0]  fold_sum;
  logic [lrig_pkg::StateW-1:0] nxt_state;
  logic                        div_start;
  logic                        div_done;
  logic [lrig_pkg::SpanW-1:0]  div_rem;

  // Take a transaction only when no request is in flight.
  assign req_i.ready = (state_q == lrig_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Fold the 46-bit product: 2^31 == 1 mod M, so add the high part to the low
  // part and subtract M once if the sum reaches it (covers a state equal to M).
  always_comb begin
    fold_sum = {1'b0, prod_q[lrig_pkg::StateW-1:0]}
             + {{(lrig_pkg::DataW - lrig_pkg::MultW){1'b0}},
                prod_q[lrig_pkg::ProdW-1:lrig_pkg::StateW]};
    if (fold_sum >= {1'b0, lrig_pkg::LcgMod}) begin
      fold_sum = fold_sum - {1'b0, lrig_pkg::LcgMod};
    end
    nxt_state = fold_sum[lrig_pkg::StateW-1:0];
  end

  always_comb begin
    state_d        = state_q;
    gen_d          = gen_q;
    prod_d         = prod_q;
    kind_d         = kind_q;
    err_d          = err_q;
    lo_d           = lo_q;
    span_d         = span_q;
    res_d          = res_q;
    out_valid_d    = out_valid_q;
    out_value_d    = out_value_q;
    out_err_d      = out_err_q;
    div_start      = 1'b0;

    // Drop the held result once the sink takes it.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      lrig_pkg::ST_IDLE: begin
        if (req_fire) begin
          kind_d = req_i.kind;
          err_d  = req_i.kind && (req_i.range_high < req_i.range_low);
          lo_d   = req_i.range_low;
          // 33-bit span, exact up to 2^32 for a full-width range
          span_d = lrig_pkg::SpanW'({req_i.range_high[lrig_pkg::DataW-1], req_i.range_high}
                 - {req_i.range_low[lrig_pkg::DataW-1], req_i.range_low} + 1'b1);
          state_d = lrig_pkg::ST_MUL;
        end
      end
      lrig_pkg::ST_MUL: begin
        prod_d  = lrig_pkg::ProdW'(gen_q) * lrig_pkg::ProdW'(lrig_pkg::LcgMult);
        state_d = lrig_pkg::ST_FOLD;
      end
      lrig_pkg::ST_FOLD: begin
        // Advance the state on every request, range error or not.
        gen_d = nxt_state;
        if (kind_q && !err_q) begin
          div_start = 1'b1;
          state_d   = lrig_pkg::ST_DIV;
        end else begin
          res_d   = kind_q ? lo_q : {1'b0, nxt_state};
          state_d = lrig_pkg::ST_DONE;
        end
      end
      lrig_pkg::ST_DIV: begin
        if (div_done) begin
          // remainder < span <= 2^32; the 32-bit add wraps like the signed sum
          res_d   = lo_q + div_rem[lrig_pkg::DataW-1:0];
          state_d = lrig_pkg::ST_DONE;
        end
      end
      lrig_pkg::ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          out_err_d   = err_q;
          state_d     = lrig_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrig_pkg::ST_IDLE;
      end
    endcase

    // Seed write reloads the state; the user must issue it only while idle (not enforced here).
    if (cfg_we_i) begin
      gen_d = cfg_wdata_i;
    end
  end

  // The remainder is taken of the freshly advanced state.
  lrig_serial_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (nxt_state),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrig_pkg::ST_IDLE;
      gen_q       <= lrig_pkg::SeedRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    kind_q      <= kind_d;
    err_q       <= err_d;
    lo_q        <= lo_d;
    span_q      <= span_d;
    res_q       <= res_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.value       = out_value_q;
  assign rsp_o.range_error = out_err_q;

endmodule
`default_nettype wire
